[src/bcdec_pkg.sv]
// Shared constants, stage types and arithmetic helpers for the BC1/BC2/BC3 block decoder.
// No dependencies.
package bcdec_pkg;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 160;

  localparam logic [13:0] MAX_DIMENSION = 14'd8192;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [12:0]       bx;
    logic [12:0]       by;
    logic [3:0]        mask;
    logic [2:0]        rows;
    logic              dxt3;
    logic              dxt5;
    logic              four_col;
    logic              six_step;
    logic [7:0]        a0;
    logic [7:0]        a1;
    logic [2:0][7:0]   e0;
    logic [2:0][7:0]   e1;
    logic [2:0][9:0]   sum_a;
    logic [2:0][9:0]   sum_b;
    logic [2:0][8:0]   sum_h;
    logic [5:0][10:0]  num7;
    logic [3:0][10:0]  num5;
    logic [63:0]       aw;
    logic [31:0]       cidx;
  } s1_t;

  typedef struct packed {
    logic [12:0]       bx;
    logic [12:0]       by;
    logic [3:0]        mask;
    logic [2:0]        rows;
    logic              dxt3;
    logic              dxt5;
    logic [63:0]       aw;
    logic [31:0]       cidx;
    logic [3:0][31:0]  pal;
    logic [7:0][7:0]   ramp;
  } s2_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x < 1024: floor(x * 683 / 2048)
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x < 2048: floor(x * 1639 / 8192)
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  // x < 2048: floor(x * 2341 / 16384)
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd2341;
    return p[21:14];
  endfunction

endpackage

[src/bc1_bc2_bc3_block_decoder.sv]
// BC1/BC2/BC3 (DXT1/DXT3/DXT5) 4x4 block decoder, three register stages.
// Depends on bcdec_pkg.
//
// One input beat is one compressed block; it yields one output beat per texel row that
// lies inside the image (up to four, top to bottom, tlast on the last), each with four
// BGRA texels and a column mask for the image width. Stage 1 expands endpoints and forms
// blend sums, stage 2 divides them into the palette and alpha ramp, stage 3 issues one
// row per cycle into the output register. A block passes the stage 1 and stage 2
// registers before its first row enters the output register. A block holds the issue
// stage until it has emitted its last row (1 to 4) while the next block waits in stage 1,
// so with a ready sink a new block enters each time the block ahead issues its last row;
// output stalls hold every stage. Blocks fully outside the image yield no beats and are
// dropped at the input. Write configuration only while no block is in flight.
module bc1_bc2_bc3_block_decoder
  import bcdec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [13:0]            cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // block_column[10:0], block_row[21:11], alpha_word[85:22], colour_word[149:86], pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // row_x[12:0], row_y[25:13], texel_zero..texel_three[153:26], column_mask[157:154], pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic [1:0]  fmt_r;
  logic [13:0] width_r;
  logic [13:0] height_r;

  logic        s1_valid_r, s1_valid_nxt;
  s1_t         s1_r, s1_nxt;
  logic        s2_valid_r, s2_valid_nxt;
  s2_t         s2_r, s2_nxt;
  logic [1:0]  row_r, row_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_load, row_fire, row_last, s2_free;
  logic [13:0] w_cl, h_cl, rem;
  logic [12:0] bx_in, by_in;
  logic        on_image;
  logic [15:0] c0, c1;
  logic [63:0] cw;
  logic [3:0][31:0] texel;
  logic [3:0]  ti;
  logic [1:0]  sel;
  logic [7:0]  alpha;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_DXT1;
      width_r  <= 14'd16;
      height_r <= 14'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FORMAT: fmt_r    <= cfg_data[1:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_load  = !out_valid_r || out_tready;
  assign row_fire  = s2_valid_r && out_load;
  assign row_last  = (({1'b0, row_r} + 3'd1) == s2_r.rows);
  assign s2_free   = !s2_valid_r || (row_fire && row_last);
  assign in_tready = !s1_valid_r || s2_free;

  // stage 1: clip, endpoint expansion, blend sums
  always_comb begin
    w_cl  = (width_r > MAX_DIMENSION) ? MAX_DIMENSION : width_r;
    h_cl  = (height_r > MAX_DIMENSION) ? MAX_DIMENSION : height_r;
    bx_in = {in_tdata[10:0], 2'b00};
    by_in = {in_tdata[21:11], 2'b00};
    cw    = in_tdata[149:86];
    c0    = cw[15:0];
    c1    = cw[31:16];
    on_image = ({1'b0, bx_in} < w_cl) && ({1'b0, by_in} < h_cl);
    rem   = h_cl - {1'b0, by_in};

    s1_nxt.bx   = bx_in;
    s1_nxt.by   = by_in;
    for (int k = 0; k < 4; k++) begin
      s1_nxt.mask[k] = (({1'b0, bx_in} + 14'(k)) < w_cl);
    end
    s1_nxt.rows     = (rem > 14'd4) ? 3'd4 : rem[2:0];
    s1_nxt.dxt3     = (fmt_r == FMT_DXT3);
    s1_nxt.dxt5     = (fmt_r == FMT_DXT5);
    s1_nxt.four_col = (fmt_r == FMT_DXT3) || (fmt_r == FMT_DXT5) || (c0 > c1);
    s1_nxt.aw       = in_tdata[85:22];
    s1_nxt.cidx     = cw[63:32];
    s1_nxt.a0       = in_tdata[29:22];
    s1_nxt.a1       = in_tdata[37:30];
    s1_nxt.six_step = (in_tdata[29:22] > in_tdata[37:30]);

    s1_nxt.e0[0] = widen5(c0[4:0]);
    s1_nxt.e0[1] = widen6(c0[10:5]);
    s1_nxt.e0[2] = widen5(c0[15:11]);
    s1_nxt.e1[0] = widen5(c1[4:0]);
    s1_nxt.e1[1] = widen6(c1[10:5]);
    s1_nxt.e1[2] = widen5(c1[15:11]);
    for (int k = 0; k < 3; k++) begin
      s1_nxt.sum_a[k] = {1'b0, s1_nxt.e0[k], 1'b0} + {2'b00, s1_nxt.e1[k]};
      s1_nxt.sum_b[k] = {2'b00, s1_nxt.e0[k]} + {1'b0, s1_nxt.e1[k], 1'b0};
      s1_nxt.sum_h[k] = {1'b0, s1_nxt.e0[k]} + {1'b0, s1_nxt.e1[k]};
    end
    for (int k = 1; k <= 6; k++) begin
      s1_nxt.num7[k-1] = 11'(7 - k) * {3'b000, s1_nxt.a0} + 11'(k) * {3'b000, s1_nxt.a1};
    end
    for (int k = 1; k <= 4; k++) begin
      s1_nxt.num5[k-1] = 11'(5 - k) * {3'b000, s1_nxt.a0} + 11'(k) * {3'b000, s1_nxt.a1};
    end
    s1_valid_nxt = in_tvalid && on_image;
  end

  // stage 2: palette and alpha ramp
  always_comb begin
    s2_nxt.bx   = s1_r.bx;
    s2_nxt.by   = s1_r.by;
    s2_nxt.mask = s1_r.mask;
    s2_nxt.rows = s1_r.rows;
    s2_nxt.dxt3 = s1_r.dxt3;
    s2_nxt.dxt5 = s1_r.dxt5;
    s2_nxt.aw   = s1_r.aw;
    s2_nxt.cidx = s1_r.cidx;
    s2_nxt.pal[0] = {8'hFF, s1_r.e0[2], s1_r.e0[1], s1_r.e0[0]};
    s2_nxt.pal[1] = {8'hFF, s1_r.e1[2], s1_r.e1[1], s1_r.e1[0]};
    s2_nxt.pal[2][31:24] = 8'hFF;
    s2_nxt.pal[3][31:24] = s1_r.four_col ? 8'hFF : 8'h00;
    for (int k = 0; k < 3; k++) begin
      s2_nxt.pal[2][8*k +: 8] = s1_r.four_col ? div3(s1_r.sum_a[k]) : s1_r.sum_h[k][8:1];
      s2_nxt.pal[3][8*k +: 8] = s1_r.four_col ? div3(s1_r.sum_b[k]) : 8'h00;
    end
    s2_nxt.ramp[0] = s1_r.a0;
    s2_nxt.ramp[1] = s1_r.a1;
    if (s1_r.six_step) begin
      for (int k = 1; k <= 6; k++) begin
        s2_nxt.ramp[1+k] = div7(s1_r.num7[k-1]);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        s2_nxt.ramp[1+k] = div5(s1_r.num5[k-1]);
      end
      s2_nxt.ramp[6] = 8'h00;
      s2_nxt.ramp[7] = 8'hFF;
    end
    s2_valid_nxt = s1_valid_r;
  end

  // stage 3: one row of texels per cycle while the output is not stalled
  always_comb begin
    texel = '0;
    ti    = '0;
    sel   = '0;
    alpha = '0;
    for (int k = 0; k < 4; k++) begin
      ti    = {row_r, 2'(k)};
      sel   = s2_r.cidx[{ti, 1'b0} +: 2];
      alpha = s2_r.pal[sel][31:24];
      if (s2_r.dxt3) begin
        alpha = {s2_r.aw[{ti, 2'b00} +: 4], s2_r.aw[{ti, 2'b00} +: 4]};
      end else if (s2_r.dxt5) begin
        alpha = s2_r.ramp[s2_r.aw[6'd16 + 6'(ti) * 6'd3 +: 3]];
      end
      texel[k] = {alpha, s2_r.pal[sel][23:0]};
    end
    out_data_nxt  = {2'b00, s2_r.mask, texel, s2_r.by + {11'd0, row_r}, s2_r.bx};
    out_last_nxt  = row_last;
    out_valid_nxt = row_fire;
    row_nxt       = s2_free ? 2'd0 : (row_fire ? row_r + 2'd1 : row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= 2'd0;
    end else begin
      if (in_tready) s1_valid_r <= s1_valid_nxt;
      if (s2_free) s2_valid_r <= s2_valid_nxt;
      if (out_load) out_valid_r <= out_valid_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) s1_r <= s1_nxt;
    if (s2_free && s1_valid_r) s2_r <= s2_nxt;
    if (row_fire) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[src/bcdec_checker.sv]
// Port-level checks for the block decoder output stream, bound to the top level.
// Depends on bcdec_pkg and bc1_bc2_bc3_block_decoder.
module bcdec_checker
  import bcdec_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed under stall");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // first texel always inside, mask is a run from bit 0
  a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[154] && (out_tdata[157] ? out_tdata[156] : 1'b1)
                   && (out_tdata[156] ? out_tdata[155] : 1'b1))
    else $error("bad column mask");

  // rows of one block arrive in order, each one row below the last in the same column
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) ##1 out_tvalid |->
      out_tdata[25:13] == $past(out_tdata[25:13]) + 13'd1 &&
      out_tdata[12:0] == $past(out_tdata[12:0]))
    else $error("row sequence broken");

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_bcdec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
